// ===== design/ampq_pkg.sv =====
`timescale 1ns / 1ps

package ampq_pkg;

    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FINISH
    } t_state;

endpackage

// ===== design/ampq_if.sv =====
`timescale 1ns / 1ps

interface ampq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [ampq_pkg::DATA_W-1:0]  value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface ampq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ampq_pkg::DATA_W-1:0]  result_value;
    logic        [ampq_pkg::STATUS_W-1:0] status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== design/array_min_priority_queue.sv =====
`timescale 1ns / 1ps
// channel   dir  word
// i_req     in   req_type (1), value (32 signed)
// o_rsp     out  result_value (32 signed), status (2)
//
// insert: result register loaded in ST_FINISH once it is free, next request taken back in ST_IDLE
// delete-min: a scan of the n live entries for the minimum, a shift of the entries above it
//   down by one, then ST_FINISH; one read port of the entry memory is walked for both
// i_req is ready only between requests; a finished word sits in the output
//   register while the next request is taken, and waits there while o_rsp stalls
// i_rst_n empties the queue at once; no clearing pass

module array_min_priority_queue #(
    parameter int CAPACITY = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ampq_req_if.sink      i_req,
    ampq_rsp_if.source    o_rsp
);
    import ampq_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    t_state r_state, n_state;

    logic [CW-1:0]              r_count, n_count;
    logic [CW-1:0]              r_idx, n_idx;
    logic [CW-1:0]              r_cmp_idx, n_cmp_idx;
    logic                       r_cmp_vld, n_cmp_vld;
    logic [CW-1:0]              r_best_idx, n_best_idx;
    logic signed [DATA_W-1:0]   r_best, n_best;
    logic [STATUS_W-1:0]        r_pend_status, n_pend_status;

    logic signed [DATA_W-1:0]   r_mem [CAPACITY];
    logic signed [DATA_W-1:0]   r_rd_data;

    logic                       r_out_valid;
    logic signed [DATA_W-1:0]   r_res_value;
    logic [STATUS_W-1:0]        r_status;

    logic                       w_accept;
    logic                       w_full;
    logic                       w_issue;
    logic                       w_scan_last;
    logic                       w_shift_done;
    logic                       w_out_load;
    logic                       w_we;
    logic [CW-1:0]              w_wsel;
    logic signed [DATA_W-1:0]   w_wdata;

    assign w_accept     = i_req.valid && i_req.ready;
    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_issue      = (r_idx < r_count);
    assign w_scan_last  = r_cmp_vld && (r_cmp_idx == r_count - CW'(1));
    assign w_shift_done = !w_issue && !r_cmp_vld;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req.req_type == REQ_DELETE && r_count != '0) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_SCAN: begin
                if (w_scan_last) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (w_shift_done) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        w_out_load  = (r_state == ST_FINISH) && (!r_out_valid || o_rsp.ready);
    end

    // datapath
    always_comb begin
        n_count       = r_count;
        n_idx         = r_idx;
        n_cmp_idx     = r_idx;
        n_cmp_vld     = 1'b0;
        n_best        = r_best;
        n_best_idx    = r_best_idx;
        n_pend_status = r_pend_status;
        w_we          = 1'b0;
        w_wsel        = r_count;
        w_wdata       = i_req.value;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_best        = '0;
                    n_best_idx    = '0;
                    n_idx         = '0;
                    n_pend_status = STATUS_OK;
                    if (i_req.req_type == REQ_INSERT) begin
                        if (w_full) begin
                            n_pend_status = STATUS_FULL;
                        end else begin
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end else if (r_count == '0) begin
                        n_pend_status = STATUS_EMPTY;
                    end
                end
            end
            ST_SCAN: begin
                if (w_issue) begin
                    n_cmp_vld = 1'b1;
                    n_idx     = r_idx + CW'(1);
                end
                if (r_cmp_vld) begin
                    if (r_cmp_idx == '0 || r_rd_data < r_best) begin
                        n_best     = r_rd_data;
                        n_best_idx = r_cmp_idx;
                    end
                    if (w_scan_last) begin
                        n_idx     = n_best_idx + CW'(1);
                        n_cmp_vld = 1'b0;
                    end
                end
            end
            ST_SHIFT: begin
                if (w_issue) begin
                    n_cmp_vld = 1'b1;
                    n_idx     = r_idx + CW'(1);
                end
                if (r_cmp_vld) begin
                    w_we    = 1'b1;
                    w_wsel  = r_cmp_idx - CW'(1);
                    w_wdata = r_rd_data;
                end
                if (w_shift_done) begin
                    n_count = r_count - CW'(1);
                end
            end
            ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cmp_vld <= n_cmp_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_cmp_idx     <= n_cmp_idx;
        r_best        <= n_best;
        r_best_idx    <= n_best_idx;
        r_pend_status <= n_pend_status;
    end

    // entry memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wsel[AW-1:0]] <= w_wdata;
        end
        r_rd_data <= r_mem[r_idx[AW-1:0]];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_res_value <= r_best;
            r_status    <= r_pend_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_res_value;
    assign o_rsp.status       = r_status;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count past capacity");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == REQ_INSERT && !w_full)
        |=> r_count == $past(r_count) + CW'(1))
        else $error("insert did not grow the queue");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SHIFT && w_shift_done)
        |=> r_count == $past(r_count) - CW'(1))
        else $error("delete did not shrink the queue");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_idx <= r_count && r_count != '0))
        else $error("scan index past live entries");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_status == STATUS_OK || r_status == STATUS_FULL
                         || r_status == STATUS_EMPTY))
        else $error("bad status code");
`endif

endmodule
